// ===== hdl/pcm_loop_sample_player_assert.svh =====
// Assertion macros for the looping sample player.
// Used by pcmlsp_seq and pcm_loop_sample_player; expects clk and rst in scope.
`ifndef PCM_LOOP_SAMPLE_PLAYER_ASSERT_SVH
`define PCM_LOOP_SAMPLE_PLAYER_ASSERT_SVH

// same-cycle implication
`define PCMLSP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pcm_loop_sample_player: assertion failed");

// next-cycle implication
`define PCMLSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pcm_loop_sample_player: assertion failed");

`endif

// ===== hdl/pcmlsp_pkg.sv =====
// Shared types and constants for the looping sample player.
// No dependencies.
package pcmlsp_pkg;

  localparam int STORE_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int POS_W       = 13;
  localparam int SMP_W       = 16;
  localparam int CNT_W       = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [POS_W:0] DEPTH_LIM = (POS_W+1)'(STORE_DEPTH);

  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_PLAY   = 3'd1;
  localparam logic [2:0] OP_STOP   = 3'd2;
  localparam logic [2:0] OP_PAUSE  = 3'd3;
  localparam logic [2:0] OP_RESUME = 3'd4;
  localparam logic [2:0] OP_SEEK   = 3'd5;
  localparam logic [2:0] OP_LOAD   = 3'd6;

  localparam logic [CFG_IDX_W-1:0] REG_RANGE_START   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_STOP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_ENABLE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LOOPS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STORED_LENGTH = 3'd4;

  typedef struct packed {
    logic [POS_W-1:0] range_start;
    logic [POS_W-1:0] range_stop;
    logic             loop_enable;
    logic [CNT_W-1:0] max_loops;
    logic [POS_W-1:0] stored_length;
  } cfg_t;

  typedef struct packed {
    logic              rd;
    logic [ADDR_W-1:0] addr;
    logic              looped;
    logic              done;
    logic              playing;
  } req_t;

endpackage

// ===== hdl/pcmlsp_seq.sv =====
// Playback sequencer: position, loop count and run flag, updated per transaction.
// Depends on pcmlsp_pkg and pcm_loop_sample_player_assert.svh.
`include "pcm_loop_sample_player_assert.svh"

module pcmlsp_seq (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     acc,
  input  logic [2:0]               op,
  input  logic [pcmlsp_pkg::POS_W-1:0] position,
  input  pcmlsp_pkg::cfg_t         cfg,
  output pcmlsp_pkg::req_t         req
);

  logic [pcmlsp_pkg::POS_W-1:0] play_pos, play_pos_next;
  logic [pcmlsp_pkg::CNT_W-1:0] loops, loops_next;
  logic                         running, running_next;

  logic                         active, at_end, wrap, fin, in_range;
  logic [pcmlsp_pkg::POS_W-1:0] p0, pos_rd;

  always_comb begin
    active   = running && (cfg.range_start < cfg.range_stop) && (cfg.stored_length != '0);
    p0       = (play_pos < cfg.range_start) ? cfg.range_start : play_pos;
    at_end   = p0 >= cfg.range_stop;
    wrap     = cfg.loop_enable && ((cfg.max_loops == '0) ||
               (({1'b0, loops} + (pcmlsp_pkg::CNT_W+1)'(1)) < {1'b0, cfg.max_loops}));
    fin      = at_end && !wrap;
    pos_rd   = at_end ? cfg.range_start : p0;
    in_range = (pos_rd < cfg.stored_length) && ({1'b0, pos_rd} < pcmlsp_pkg::DEPTH_LIM);

    play_pos_next = play_pos;
    loops_next    = loops;
    running_next  = running;
    req.rd        = 1'b0;
    req.addr      = pos_rd[pcmlsp_pkg::ADDR_W-1:0];
    req.looped    = 1'b0;
    req.done      = 1'b0;

    case (op)
      pcmlsp_pkg::OP_TICK: begin
        if (!active) begin
          req.done = !cfg.loop_enable;
        end else if (fin) begin
          req.done      = 1'b1;
          running_next  = 1'b0;
          play_pos_next = p0;
        end else begin
          req.rd        = in_range;
          req.looped    = at_end;
          play_pos_next = pos_rd + pcmlsp_pkg::POS_W'(1);
          if (at_end) begin
            loops_next = loops + pcmlsp_pkg::CNT_W'(1);
          end
        end
      end
      pcmlsp_pkg::OP_PLAY, pcmlsp_pkg::OP_STOP: begin
        running_next  = (op == pcmlsp_pkg::OP_PLAY);
        play_pos_next = cfg.range_start;
        loops_next    = '0;
      end
      pcmlsp_pkg::OP_PAUSE:  running_next  = 1'b0;
      pcmlsp_pkg::OP_RESUME: running_next  = 1'b1;
      pcmlsp_pkg::OP_SEEK:   play_pos_next = position;
      default: ;
    endcase

    req.playing = running_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      play_pos <= '0;
      loops    <= '0;
      running  <= 1'b0;
    end else if (acc) begin
      play_pos <= play_pos_next;
      loops    <= loops_next;
      running  <= running_next;
    end
  end

  `PCMLSP_ASSERT_NEXT(a_end_stops, acc && op == pcmlsp_pkg::OP_TICK && active && fin, !running)
  `PCMLSP_ASSERT_NEXT(a_play_rewinds, acc && op == pcmlsp_pkg::OP_PLAY,
                      running && loops == '0)

endmodule

// ===== hdl/pcm_loop_sample_player.sv =====
// Looping PCM sample player, top level: config registers, sample store, output pipe.
// Depends on pcmlsp_pkg, pcmlsp_seq and pcm_loop_sample_player_assert.svh.
//
// Usage:
//   Input channel (in_valid/in_stall) carries op, position and sample_in. Ops:
//   tick, play, stop, pause, resume, seek, load sample. Every transaction gives
//   exactly one result on the output channel (out_valid/out_stall): sample_out,
//   looped, done_res and playing.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes range_start,
//   range_stop, loop_enable, max_loops and stored_length; cfg_ready is always high.
//   From an input transaction to out_valid: the sample store read is registered,
//   then the result register. Throughput is one transaction per cycle while
//   the output is not stalled, set by the single store read port.
//   When the receiver stalls, the result register holds and one more item waits
//   in the read stage; in_stall rises once both are full.
//   Reset clears the run flag, position and loop count and loads register
//   defaults (loop_enable 1, others 0). The store is not cleared; samples must be
//   loaded before they are played.
`include "pcm_loop_sample_player_assert.svh"

module pcm_loop_sample_player (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [2:0]                           op,
  input  logic [pcmlsp_pkg::POS_W-1:0]         position,
  input  logic signed [pcmlsp_pkg::SMP_W-1:0]  sample_in,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [pcmlsp_pkg::SMP_W-1:0]  sample_out,
  output logic                                 looped,
  output logic                                 done_res,
  output logic                                 playing,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pcmlsp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pcmlsp_pkg::CFG_DATA_W-1:0]    cfg_data
);

  pcmlsp_pkg::cfg_t cfg;
  pcmlsp_pkg::req_t req;
  pcmlsp_pkg::req_t s1;

  logic                          acc;
  logic                          s1_valid, s1_move;
  logic [pcmlsp_pkg::SMP_W-1:0]  rdata;
  logic [pcmlsp_pkg::SMP_W-1:0]  mem [pcmlsp_pkg::STORE_DEPTH];

  assign cfg_ready = 1'b1;
  assign s1_move   = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !s1_move;
  assign acc       = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.range_start   <= '0;
      cfg.range_stop    <= '0;
      cfg.loop_enable   <= 1'b1;
      cfg.max_loops     <= '0;
      cfg.stored_length <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pcmlsp_pkg::REG_RANGE_START:   cfg.range_start   <= cfg_data[pcmlsp_pkg::POS_W-1:0];
        pcmlsp_pkg::REG_RANGE_STOP:    cfg.range_stop    <= cfg_data[pcmlsp_pkg::POS_W-1:0];
        pcmlsp_pkg::REG_LOOP_ENABLE:   cfg.loop_enable   <= cfg_data[0];
        pcmlsp_pkg::REG_MAX_LOOPS:     cfg.max_loops     <= cfg_data[pcmlsp_pkg::CNT_W-1:0];
        pcmlsp_pkg::REG_STORED_LENGTH: cfg.stored_length <= cfg_data[pcmlsp_pkg::POS_W-1:0];
        default: ;
      endcase
    end
  end

  pcmlsp_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .acc      (acc),
    .op       (op),
    .position (position),
    .cfg      (cfg),
    .req      (req)
  );

  // sample store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (acc && op == pcmlsp_pkg::OP_LOAD && {1'b0, position} < pcmlsp_pkg::DEPTH_LIM) begin
      mem[position[pcmlsp_pkg::ADDR_W-1:0]] <= sample_in;
    end
    if (acc) begin
      rdata <= mem[req.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (acc) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1 <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      sample_out <= s1.rd ? rdata : '0;
      looped     <= s1.looped;
      done_res   <= s1.done;
      playing    <= s1.playing;
    end
  end

  `PCMLSP_ASSERT_NEXT(a_s1_holds, s1_valid && !s1_move, s1_valid && $stable(s1))
  `PCMLSP_ASSERT_NOW(a_loop_not_done, out_valid, !(looped && done_res))
  `PCMLSP_ASSERT_NOW(a_loop_plays, out_valid && looped, playing)

endmodule
